/* sv/ecr3d_pkg.sv */
// Types, stage map and per-stage arithmetic for the elastic collision response pipeline.
package ecr3d_pkg;

   // Fixed-point formats of the internal values.
   localparam int UNIT_FRAC  = 28;
   localparam int RATIO_FRAC = 30;

   // Step counts of the iterative sections.
   localparam int NORM_STEPS = 5;
   localparam int NORM_TOP   = 16;
   localparam int ROOT_STEPS = 32;
   localparam int WDIV_STEPS = 31;
   localparam int UDIV_STEPS = 29;

   // Stage map of the pipeline.
   localparam int ST_PREP      = 0;
   localparam int ST_NORM0     = ST_PREP + 1;
   localparam int ST_SQ        = ST_NORM0 + NORM_STEPS;
   localparam int ST_SUM       = ST_SQ + 1;
   localparam int ST_ROOT0     = ST_SUM + 1;
   localparam int ST_UDIV_INIT = ST_ROOT0 + ROOT_STEPS;
   localparam int ST_UDIV0     = ST_UDIV_INIT + 1;
   localparam int ST_PROJ_MUL  = ST_UDIV0 + UDIV_STEPS;
   localparam int ST_PROJ_SUM  = ST_PROJ_MUL + 1;
   localparam int ST_PROJ_RND  = ST_PROJ_SUM + 1;
   localparam int ST_DW_MUL    = ST_PROJ_RND + 1;
   localparam int ST_DW_ADD    = ST_DW_MUL + 1;
   localparam int ST_DW_RND    = ST_DW_ADD + 1;
   localparam int ST_UP_MUL    = ST_DW_RND + 1;
   localparam int ST_UP_ADD    = ST_UP_MUL + 1;
   localparam int ST_OUT       = ST_UP_ADD + 1;
   localparam int NUM_STAGES   = ST_OUT + 1;

   localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
   localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

   // Everything one body pair carries down the pipeline. Index 0 is body a, 1 is body b.
   typedef struct packed {
      logic                   pass;
      logic [31:0]            gap;
      logic [31:0]            ma;
      logic [31:0]            mb;
      logic [32:0]            tot;
      logic [1:0][2:0][31:0]  vel;
      logic [2:0][31:0]       off;
      logic [2:0]             neg;
      logic [2:0][31:0]       ad;
      logic [31:0]            mx;
      logic [2:0][63:0]       sq;
      logic [63:0]            root_n;
      logic [63:0]            root_r;
      logic [1:0][62:0]       wnum;
      logic [1:0][33:0]       wrem;
      logic [1:0][30:0]       wq;
      logic [31:0]            len;
      logic [2:0][60:0]       unum;
      logic [2:0][32:0]       urem;
      logic [2:0][28:0]       uq;
      logic [2:0][29:0]       u;
      logic [1:0][2:0][61:0]  pprod;
      logic [1:0][63:0]       psum;
      logic [1:0][33:0]       proj;
      logic [1:0][47:0]       dlo;
      logic [1:0][49:0]       dhi;
      logic [1:0][66:0]       dprod;
      logic [1:0][35:0]       dv;
      logic [1:0][2:0][47:0]  elo;
      logic [1:0][2:0][48:0]  ehi;
      logic [1:0][2:0][63:0]  eprod;
      logic [1:0][2:0][31:0]  nv;
   } stage_data_type;

   // Divide by 2^k, rounding half away from zero.
   function automatic logic [67:0] rnd_half_away(input logic signed [67:0] x, input int k);
      logic [67:0] mag;
      logic [67:0] m;
      mag = x[67] ? (68'd0 - x) : x;
      m = (mag + (68'd1 << (k - 1))) >> k;
      return x[67] ? (68'd0 - m) : m;
   endfunction

   // Magnitudes, largest offset component, total mass, bypass decision and setup of the mass-weight divisions.
   function automatic stage_data_type prep_stage(input stage_data_type c);
      stage_data_type r;
      logic [32:0] t;
      r = c;
      for (int i = 0; i < 3; i++) begin
         r.neg[i] = c.off[i][31];
         r.ad[i] = c.off[i][31] ? (32'd0 - c.off[i]) : c.off[i];
      end
      r.mx = r.ad[0];
      if (r.ad[1] > r.mx) r.mx = r.ad[1];
      if (r.ad[2] > r.mx) r.mx = r.ad[2];
      t = {1'b0, c.ma} + {1'b0, c.mb};
      r.tot = t;
      r.pass = ($signed(c.gap) > 32'sd0) || (r.mx == 32'd0) || (t == 33'd0);
      r.wnum[0] = 63'({c.ma, 30'd0}) + 63'(t >> 1);
      r.wnum[1] = 63'({c.mb, 30'd0}) + 63'(t >> 1);
      for (int w = 0; w < 2; w++) begin
         r.wrem[w] = 34'(r.wnum[w] >> 31);
         r.wq[w] = '0;
      end
      return r;
   endfunction

   // One step of the normalizing shift: move the offset up by sh bits if room is left.
   function automatic stage_data_type norm_stage(input stage_data_type c, input int sh);
      stage_data_type r;
      r = c;
      if ((c.mx >> (31 - sh)) == 32'd0) begin
         r.mx = c.mx << sh;
         for (int i = 0; i < 3; i++) r.ad[i] = c.ad[i] << sh;
      end
      return r;
   endfunction

   // One result bit of the square root and, in the first WDIV_STEPS steps, one quotient bit of each mass weight.
   function automatic stage_data_type root_stage(input stage_data_type c, input int j);
      stage_data_type r;
      logic [63:0] bitv;
      logic [63:0] t;
      logic [33:0] rr;
      int b;
      r = c;
      bitv = 64'd1 << (62 - 2 * j);
      t = c.root_r + bitv;
      if (c.root_n >= t) begin
         r.root_n = c.root_n - t;
         r.root_r = (c.root_r >> 1) + bitv;
      end else begin
         r.root_r = c.root_r >> 1;
      end
      if (j < WDIV_STEPS) begin
         b = WDIV_STEPS - 1 - j;
         for (int w = 0; w < 2; w++) begin
            rr = {c.wrem[w][32:0], c.wnum[w][b]};
            if (rr >= {1'b0, c.tot}) begin
               r.wrem[w] = rr - {1'b0, c.tot};
               r.wq[w][b] = 1'b1;
            end else begin
               r.wrem[w] = rr;
            end
         end
      end
      return r;
   endfunction

   // Set up the three unit-vector divisions by the length.
   function automatic stage_data_type udiv_init_stage(input stage_data_type c);
      stage_data_type r;
      r = c;
      r.len = c.root_r[31:0];
      for (int i = 0; i < 3; i++) begin
         r.unum[i] = 61'({c.ad[i], 28'd0}) + 61'(c.root_r[31:0] >> 1);
         r.urem[i] = 33'(r.unum[i] >> 29);
         r.uq[i] = '0;
      end
      return r;
   endfunction

   // One quotient bit of each unit-vector component.
   function automatic stage_data_type udiv_stage(input stage_data_type c, input int j);
      stage_data_type r;
      logic [32:0] rr;
      int b;
      r = c;
      b = UDIV_STEPS - 1 - j;
      for (int i = 0; i < 3; i++) begin
         rr = {c.urem[i][31:0], c.unum[i][b]};
         if (rr >= {1'b0, c.len}) begin
            r.urem[i] = rr - {1'b0, c.len};
            r.uq[i][b] = 1'b1;
         end else begin
            r.urem[i] = rr;
         end
      end
      return r;
   endfunction

   // Signed unit vector and the products of each velocity with it.
   function automatic stage_data_type proj_mul_stage(input stage_data_type c);
      stage_data_type r;
      logic signed [29:0] su;
      logic signed [61:0] pr;
      r = c;
      for (int i = 0; i < 3; i++) begin
         su = c.neg[i] ? -$signed({1'b0, c.uq[i]}) : $signed({1'b0, c.uq[i]});
         r.u[i] = su;
         for (int s = 0; s < 2; s++) begin
            pr = $signed(c.vel[s][i]) * su;
            r.pprod[s][i] = pr;
         end
      end
      return r;
   endfunction

   function automatic stage_data_type proj_sum_stage(input stage_data_type c);
      stage_data_type r;
      logic signed [63:0] acc;
      r = c;
      for (int s = 0; s < 2; s++) begin
         acc = $signed(c.pprod[s][0]) + $signed(c.pprod[s][1]) + $signed(c.pprod[s][2]);
         r.psum[s] = acc;
      end
      return r;
   endfunction

   function automatic stage_data_type proj_rnd_stage(input stage_data_type c);
      stage_data_type r;
      logic [67:0] t;
      r = c;
      for (int s = 0; s < 2; s++) begin
         t = rnd_half_away(68'($signed(c.psum[s])), UNIT_FRAC);
         r.proj[s] = t[33:0];
      end
      return r;
   endfunction

   // Weighted speed difference, split into two partial products per body.
   function automatic stage_data_type dw_mul_stage(input stage_data_type c);
      stage_data_type r;
      logic signed [34:0] diff;
      logic [30:0] w;
      logic [47:0] lo;
      logic signed [49:0] hi;
      r = c;
      for (int s = 0; s < 2; s++) begin
         if (s == 0) begin
            diff = $signed(c.proj[1]) - $signed(c.proj[0]);
            w = c.wq[1];
         end else begin
            diff = $signed(c.proj[0]) - $signed(c.proj[1]);
            w = c.wq[0];
         end
         lo = diff[16:0] * w;
         hi = $signed(diff[34:17]) * $signed({1'b0, w});
         r.dlo[s] = lo;
         r.dhi[s] = hi;
      end
      return r;
   endfunction

   function automatic stage_data_type dw_add_stage(input stage_data_type c);
      stage_data_type r;
      logic signed [66:0] acc;
      r = c;
      for (int s = 0; s < 2; s++) begin
         acc = ($signed(c.dhi[s]) <<< 17) + $signed({1'b0, c.dlo[s]});
         r.dprod[s] = acc;
      end
      return r;
   endfunction

   // The factor of two folds into the rounding shift.
   function automatic stage_data_type dw_rnd_stage(input stage_data_type c);
      stage_data_type r;
      logic [67:0] t;
      r = c;
      for (int s = 0; s < 2; s++) begin
         t = rnd_half_away(68'($signed(c.dprod[s])), RATIO_FRAC - 1);
         r.dv[s] = t[35:0];
      end
      return r;
   endfunction

   // Speed change times each unit component, split into two partial products.
   function automatic stage_data_type up_mul_stage(input stage_data_type c);
      stage_data_type r;
      logic signed [47:0] lo;
      logic signed [48:0] hi;
      r = c;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < 3; i++) begin
            lo = $signed({1'b0, c.dv[s][16:0]}) * $signed(c.u[i]);
            hi = $signed(c.dv[s][35:17]) * $signed(c.u[i]);
            r.elo[s][i] = lo;
            r.ehi[s][i] = hi;
         end
      end
      return r;
   endfunction

   function automatic stage_data_type up_add_stage(input stage_data_type c);
      stage_data_type r;
      logic signed [63:0] acc;
      r = c;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < 3; i++) begin
            acc = ($signed(c.ehi[s][i]) <<< 17) + $signed(c.elo[s][i]);
            r.eprod[s][i] = acc;
         end
      end
      return r;
   endfunction

   // Final rounding, add to the incoming velocity and clamp; bypassed pairs keep theirs.
   function automatic stage_data_type out_stage(input stage_data_type c);
      stage_data_type r;
      logic [67:0] t;
      logic signed [36:0] acc;
      r = c;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < 3; i++) begin
            t = rnd_half_away(68'($signed(c.eprod[s][i])), UNIT_FRAC);
            acc = $signed(c.vel[s][i]) + $signed(t[35:0]);
            if (c.pass) r.nv[s][i] = c.vel[s][i];
            else if (acc > SAT_HI) r.nv[s][i] = 32'h7FFF_FFFF;
            else if (acc < SAT_LO) r.nv[s][i] = 32'h8000_0000;
            else r.nv[s][i] = acc[31:0];
         end
      end
      return r;
   endfunction

   // Work done by stage k of the pipeline.
   function automatic stage_data_type stage_fn(input stage_data_type c, input int k);
      stage_data_type r;
      r = c;
      if (k == ST_PREP) r = prep_stage(c);
      else if (k < ST_SQ) r = norm_stage(c, NORM_TOP >> (k - ST_NORM0));
      else if (k == ST_SQ) begin
         for (int i = 0; i < 3; i++) r.sq[i] = c.ad[i] * c.ad[i];
      end else if (k == ST_SUM) begin
         r.root_n = c.sq[0] + c.sq[1] + c.sq[2];
         r.root_r = '0;
      end else if (k < ST_UDIV_INIT) r = root_stage(c, k - ST_ROOT0);
      else if (k == ST_UDIV_INIT) r = udiv_init_stage(c);
      else if (k < ST_PROJ_MUL) r = udiv_stage(c, k - ST_UDIV0);
      else if (k == ST_PROJ_MUL) r = proj_mul_stage(c);
      else if (k == ST_PROJ_SUM) r = proj_sum_stage(c);
      else if (k == ST_PROJ_RND) r = proj_rnd_stage(c);
      else if (k == ST_DW_MUL) r = dw_mul_stage(c);
      else if (k == ST_DW_ADD) r = dw_add_stage(c);
      else if (k == ST_DW_RND) r = dw_rnd_stage(c);
      else if (k == ST_UP_MUL) r = up_mul_stage(c);
      else if (k == ST_UP_ADD) r = up_add_stage(c);
      else r = out_stage(c);
      return r;
   endfunction

endpackage

/* sv/elastic_collision_response_3d_unit.sv */
// Top level of the elastic collision response pipeline for one body pair per transfer.
//
// Usage: present a body pair on the req_ channel (gap, masses, both velocities and the
// offset of body a from body b, all Q16.16) with req_valid high; the transfer happens at
// a rising edge where req_stall is low. Each transfer yields exactly one result on the
// rsp_ channel: both new velocities and rsp_collided, which is high when the line of
// centers response was applied (gap at or below zero, nonzero offset, nonzero total mass).
// One pair can enter in every cycle unless a held result stalls the pipeline. The length
// comes from a 32-step square root, one result bit per stage, and the unit vector from
// three 29-step restoring dividers, which set most of the pipeline depth.
// No speed threshold is applied, so no velocity is zeroed.
// Reset clears all stage valid bits; no result is presented afterwards until new input.
// While a result waits with rsp_stall high, the whole pipeline holds and req_stall is
// raised, so nothing is lost or repeated; results leave in input order.
module elastic_collision_response_3d_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_gap,
   input  logic        [31:0] req_mass_a,
   input  logic        [31:0] req_mass_b,
   input  logic signed [31:0] req_vel_a_x,
   input  logic signed [31:0] req_vel_a_y,
   input  logic signed [31:0] req_vel_a_z,
   input  logic signed [31:0] req_vel_b_x,
   input  logic signed [31:0] req_vel_b_y,
   input  logic signed [31:0] req_vel_b_z,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   input  logic signed [31:0] req_offset_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_vel_a_x,
   output logic signed [31:0] rsp_new_vel_a_y,
   output logic signed [31:0] rsp_new_vel_a_z,
   output logic signed [31:0] rsp_new_vel_b_x,
   output logic signed [31:0] rsp_new_vel_b_y,
   output logic signed [31:0] rsp_new_vel_b_z,
   output logic               rsp_collided
);
   import ecr3d_pkg::*;

   stage_data_type          raw;
   stage_data_type          ctx_in [NUM_STAGES];
   stage_data_type          ctx_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES-1:0]   valid_ff;
   logic                    advance;

   // The pipeline moves as one unless a finished result is held at the output.
   assign advance = !(valid_ff[NUM_STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   // Gather the input fields into the stage record.
   always_comb begin
      raw = '0;
      raw.gap = req_gap;
      raw.ma = req_mass_a;
      raw.mb = req_mass_b;
      raw.vel[0][0] = req_vel_a_x;
      raw.vel[0][1] = req_vel_a_y;
      raw.vel[0][2] = req_vel_a_z;
      raw.vel[1][0] = req_vel_b_x;
      raw.vel[1][1] = req_vel_b_y;
      raw.vel[1][2] = req_vel_b_z;
      raw.off[0] = req_offset_x;
      raw.off[1] = req_offset_y;
      raw.off[2] = req_offset_z;
   end

   // Per-stage arithmetic and valid flow.
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign ctx_in[k] = stage_fn(raw, k);
         assign valid_in[k] = req_valid;
      end else begin : g_next
         assign ctx_in[k] = stage_fn(ctx_ff[k-1], k);
         assign valid_in[k] = valid_ff[k-1];
      end
   end

   // Stage registers: valid bits are reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) ctx_ff[k] <= ctx_in[k];
      end
   end

   // Result channel comes straight from the last stage register.
   assign rsp_valid       = valid_ff[NUM_STAGES-1];
   assign rsp_new_vel_a_x = ctx_ff[NUM_STAGES-1].nv[0][0];
   assign rsp_new_vel_a_y = ctx_ff[NUM_STAGES-1].nv[0][1];
   assign rsp_new_vel_a_z = ctx_ff[NUM_STAGES-1].nv[0][2];
   assign rsp_new_vel_b_x = ctx_ff[NUM_STAGES-1].nv[1][0];
   assign rsp_new_vel_b_y = ctx_ff[NUM_STAGES-1].nv[1][1];
   assign rsp_new_vel_b_z = ctx_ff[NUM_STAGES-1].nv[1][2];
   assign rsp_collided    = !ctx_ff[NUM_STAGES-1].pass;

endmodule

/* verif/elastic_collision_response_3d_unit_tb.sv */
// Self-checking testbench for the elastic collision response unit.
`timescale 1ns / 100ps

module elastic_collision_response_3d_unit_tb;

   localparam int UNIT_Q  = 28;
   localparam int RATIO_Q = 30;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [31:0] gap;
      logic        [31:0] ma;
      logic        [31:0] mb;
      logic signed [31:0] va [3];
      logic signed [31:0] vb [3];
      logic signed [31:0] off [3];
   } pair_type;

   typedef struct {
      logic signed [31:0] na [3];
      logic signed [31:0] nb [3];
      logic               hit;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_gap = '0;
   logic        [31:0] req_mass_a = '0, req_mass_b = '0;
   logic signed [31:0] req_vel_a_x = '0, req_vel_a_y = '0, req_vel_a_z = '0;
   logic signed [31:0] req_vel_b_x = '0, req_vel_b_y = '0, req_vel_b_z = '0;
   logic signed [31:0] req_offset_x = '0, req_offset_y = '0, req_offset_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_new_vel_a_x, rsp_new_vel_a_y, rsp_new_vel_a_z;
   logic signed [31:0] rsp_new_vel_b_x, rsp_new_vel_b_y, rsp_new_vel_b_z;
   logic rsp_collided;

   response_type expected_responses [$];
   int mismatch_count = 0;
   int received_count = 0;
   int hold_cycles = 0;
   bit rsp_idle_en = 1'b1;

   elastic_collision_response_3d_unit u_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Divide by a power of two with rounding half away from zero.
   function automatic longint round_shift(input longint x, input int k);
      longint unsigned m;
      m = ((x < 0) ? -x : x);
      m = (m + (64'd1 << (k - 1))) >> k;
      return (x < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Line-of-centers elastic exchange in fixed point.
   function automatic response_type collide(input pair_type p);
      response_type r;
      longint unsigned ad [3];
      longint unsigned mx, tot, sum, len, q, wa, wb;
      longint u [3];
      longint pa, pb, da, db;
      int sh;
      mx = 0;
      sum = 0;
      pa = 0;
      pb = 0;
      for (int i = 0; i < 3; i++) begin
         ad[i] = (p.off[i] < 0) ? -longint'(p.off[i]) : longint'(p.off[i]);
         if (ad[i] > mx) mx = ad[i];
      end
      tot = longint'(p.ma) + longint'(p.mb);
      r.hit = !(p.gap > 0 || mx == 0 || tot == 0);
      for (int i = 0; i < 3; i++) begin
         r.na[i] = p.va[i];
         r.nb[i] = p.vb[i];
      end
      if (!r.hit) return r;
      sh = 0;
      while ((mx << sh) < (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) begin
         ad[i] <<= sh;
         sum += ad[i] * ad[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((ad[i] << UNIT_Q) + len / 2) / len;
         u[i] = (p.off[i] < 0) ? -longint'(q) : longint'(q);
         pa += longint'(p.va[i]) * u[i];
         pb += longint'(p.vb[i]) * u[i];
      end
      pa = round_shift(pa, UNIT_Q);
      pb = round_shift(pb, UNIT_Q);
      wa = ((longint'(p.ma) << RATIO_Q) + tot / 2) / tot;
      wb = ((longint'(p.mb) << RATIO_Q) + tot / 2) / tot;
      da = round_shift(longint'(wb) * (pb - pa), RATIO_Q - 1);
      db = round_shift(longint'(wa) * (pa - pb), RATIO_Q - 1);
      for (int i = 0; i < 3; i++) begin
         r.na[i] = clamp32(p.va[i] + round_shift(da * u[i], UNIT_Q));
         r.nb[i] = clamp32(p.vb[i] + round_shift(db * u[i], UNIT_Q));
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 3);
         3: return -$urandom_range(0, 3);
         4: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic pair_type random_pair(input bit touching);
      pair_type p;
      p.gap = touching ? -$urandom_range(0, 32'h0001_0000) : rand_word();
      p.ma = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h00FF_FFFF);
      p.mb = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
      for (int i = 0; i < 3; i++) begin
         p.va[i] = rand_word();
         p.vb[i] = rand_word();
         p.off[i] = rand_word();
      end
      return p;
   endfunction

   // Offer one pair and wait for its transfer; an idle gap may come first.
   // Valid stays high after the transfer so the next pair can follow back to back.
   task automatic send_pair(input pair_type p, input bit gaps = 1'b1);
      int gap_len;
      if (gaps && $urandom_range(0, 3) == 0) begin
         gap_len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gap <= p.gap;
      req_mass_a <= p.ma;
      req_mass_b <= p.mb;
      {req_vel_a_x, req_vel_a_y, req_vel_a_z} <= {p.va[0], p.va[1], p.va[2]};
      {req_vel_b_x, req_vel_b_y, req_vel_b_z} <= {p.vb[0], p.vb[1], p.vb[2]};
      {req_offset_x, req_offset_y, req_offset_z} <= {p.off[0], p.off[1], p.off[2]};
      expected_responses.push_back(collide(p));
      do @(posedge clock); while (req_stall);
   endtask

   function automatic pair_type basic_pair();
      pair_type p;
      p.gap = 0;
      p.ma = 32'h0001_0000;
      p.mb = 32'h0002_0000;
      p.va = '{32'sh0001_0000, 32'sh0000_8000, -32'sh0000_4000};
      p.vb = '{-32'sh0002_0000, 32'sh0, 32'sh0001_0000};
      p.off = '{32'sh0001_0000, 32'sh0, 32'sh0};
      return p;
   endfunction

   // Field extremes, pass-through cases and saturating exchanges.
   task automatic test_directed();
      pair_type p;
      send_pair(basic_pair());
      p = basic_pair(); p.gap = 32'sh7FFF_FFFF; send_pair(p);
      p = basic_pair(); p.gap = 1; send_pair(p);
      p = basic_pair(); p.gap = 32'sh8000_0000; send_pair(p);
      p = basic_pair(); p.off = '{0, 0, 0}; send_pair(p);
      p = basic_pair(); p.ma = 0; p.mb = 0; send_pair(p);
      p = basic_pair(); p.ma = 0; send_pair(p);
      p = basic_pair(); p.ma = 32'hFFFF_FFFF; p.mb = 32'hFFFF_FFFF; send_pair(p);
      p = basic_pair(); p.ma = 32'hFFFF_FFFF; p.mb = 1; send_pair(p);
      p = basic_pair(); p.va = '{0, 0, 0}; p.vb = '{0, 0, 0}; send_pair(p);
      p = basic_pair(); p.va = '{1, 0, 0}; p.vb = '{-1, 0, 0}; send_pair(p);
      p = basic_pair(); p.off = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; send_pair(p);
      p = basic_pair(); p.off = '{32'sh7FFF_FFFF, -1, 1}; send_pair(p);
      p = basic_pair(); p.off = '{0, 0, 1}; send_pair(p);
      p = basic_pair(); p.off = '{-3, 5, 0}; send_pair(p);
      p = basic_pair();
      p.va = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      p.vb = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
      p.off = '{1, 1, 1};
      send_pair(p);
      p.va = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
      p.vb = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      p.ma = 1; p.mb = 32'hFFFF_FFFF;
      send_pair(p);
      p.off = '{-1, -1, -1}; send_pair(p);
   endtask

   // Mostly touching pairs with random content, some separated noise.
   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) send_pair(random_pair($urandom_range(0, 3) != 0));
   endtask

   // Long receiver hold while the sender keeps offering back to back.
   task automatic test_backpressure();
      hold_cycles = 300;
      for (int n = 0; n < 150; n++) send_pair(random_pair(1'b1), 1'b0);
   endtask

   // Sender pauses until the pipeline has fully drained.
   task automatic test_drain_pause();
      test_random(20);
      req_valid <= 1'b0;
      wait (expected_responses.size() == 0);
      test_random(20);
   endtask

   // Receiver stall: a counted hold when requested, else random gaps.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (!rsp_idle_en) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      response_type exp_r;
      response_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.na = '{rsp_new_vel_a_x, rsp_new_vel_a_y, rsp_new_vel_a_z};
         got.nb = '{rsp_new_vel_b_x, rsp_new_vel_b_y, rsp_new_vel_b_z};
         got.hit = rsp_collided;
         received_count++;
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer %0d", received_count);
         end else begin
            exp_r = expected_responses.pop_front();
            if (got.na != exp_r.na || got.nb != exp_r.nb || got.hit != exp_r.hit) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %0d mismatch: expected a=%h,%h,%h b=%h,%h,%h c=%b",
                     received_count, exp_r.na[0], exp_r.na[1], exp_r.na[2],
                     exp_r.nb[0], exp_r.nb[1], exp_r.nb[2], exp_r.hit);
                  $display("   actual a=%h,%h,%h b=%h,%h,%h c=%b",
                     got.na[0], got.na[1], got.na[2], got.nb[0], got.nb[1], got.nb[2], got.hit);
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(900);
      test_backpressure();
      test_drain_pause();
      rsp_idle_en = 1'b0;
      test_random(300);
      rsp_idle_en = 1'b1;
      test_random(600);
      req_valid <= 1'b0;
      wait (expected_responses.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("elastic_collision_response_3d_unit test passed");
      else
         $display("elastic_collision_response_3d_unit test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("elastic_collision_response_3d_unit test failed");
      $finish;
   end

endmodule
